// ----- rtl/vuap_pkg.sv -----
// Package: shared constants, codes and controller/datapath link types.
`timescale 1ns / 1ps
package vuap_pkg;

  // Memory sizes
  localparam int VRAM_BANK_BYTES_C = 8192;
  localparam int OAM_BYTES_C       = 160;
  localparam int PALETTE_BYTES_C   = 64;

  // Bus commands (code 3 means nothing and has no effect)
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SPEED = 2'd2
  } cmd_t;

  // Display modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_SCAN   = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  // Address map
  localparam logic [15:0] VRAM_BASE = 16'h8000;
  localparam logic [15:0] OAM_BASE  = 16'hFE00;
  localparam logic [15:0] ADDR_LCDC = 16'hFF40;
  localparam logic [15:0] ADDR_STAT = 16'hFF41;
  localparam logic [15:0] ADDR_SCY  = 16'hFF42;
  localparam logic [15:0] ADDR_SCX  = 16'hFF43;
  localparam logic [15:0] ADDR_LY   = 16'hFF44;
  localparam logic [15:0] ADDR_LYC  = 16'hFF45;
  localparam logic [15:0] ADDR_DMA  = 16'hFF46;
  localparam logic [15:0] ADDR_BGP  = 16'hFF47;
  localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
  localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
  localparam logic [15:0] ADDR_WY   = 16'hFF4A;
  localparam logic [15:0] ADDR_WX   = 16'hFF4B;
  localparam logic [15:0] ADDR_KEY1 = 16'hFF4D;
  localparam logic [15:0] ADDR_VBK  = 16'hFF4F;
  localparam logic [15:0] ADDR_BCPS = 16'hFF68;
  localparam logic [15:0] ADDR_BCPD = 16'hFF69;
  localparam logic [15:0] ADDR_OCPS = 16'hFF6A;
  localparam logic [15:0] ADDR_OCPD = 16'hFF6B;

  // Read masks
  localparam logic [7:0] OPEN_BUS   = 8'hFF;
  localparam logic [7:0] STAT_TOP   = 8'h80;
  localparam logic [7:0] KEY1_ONES  = 8'h7E;
  localparam logic [7:0] VBK_ONES   = 8'hFE;
  localparam logic [7:0] PIDX_ONES  = 8'h40;

  // Controller -> datapath commands
  typedef struct packed {
    logic clear_en;   // memory clearing sweep step
    logic accept;     // input transfer this cycle
    logic load_out;   // load result register
  } vuap_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic clear_last; // sweep at last entry
  } vuap_stat_t;

endpackage

// ----- rtl/vuap_ifs.sv -----
// Interfaces: request and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface vuap_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [1:0]  ppu_mode;
  logic [7:0]  current_line;
  logic [2:0]  stat_status;

  modport source (output valid, cmd, address, write_data, ppu_mode, current_line,
                  stat_status, input ready);
  modport sink   (input valid, cmd, address, write_data, ppu_mode, current_line,
                  stat_status, output ready);
endinterface

interface vuap_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        dma_start;
  logic [15:0] dma_source;
  logic        double_speed;

  modport source (output valid, read_data, dma_start, dma_source, double_speed,
                  input ready);
  modport sink   (input valid, read_data, dma_start, dma_source, double_speed,
                  output ready);
endinterface

// ----- rtl/vuap_ctrl.sv -----
// Controller: clear sweep, request acceptance and result register handoff.
`timescale 1ns / 1ps
module vuap_ctrl
  import vuap_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  vuap_stat_t stat_i,
  output vuap_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd_o          = '0;
    in_ready       = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (stat_i.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.accept = 1'b1;
          state_nxt    = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // memory read data is ready now; wait for a free result register
        if (!out_valid_r || out_ready) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_o.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/vuap_dp.sv -----
// Datapath: address decode, display registers, memories and result register.
`timescale 1ns / 1ps
module vuap_dp
  import vuap_pkg::*;
#(
  parameter int VRAM_BANK_BYTES = VRAM_BANK_BYTES_C,
  parameter int OAM_BYTES       = OAM_BYTES_C,
  parameter int PALETTE_BYTES   = PALETTE_BYTES_C
) (
  input  logic        clk,
  input  logic        rst_n,
  input  vuap_cmd_t   cmd_i,
  output vuap_stat_t  stat_o,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [1:0]  in_ppu_mode,
  input  logic [7:0]  in_current_line,
  input  logic [2:0]  in_stat_status,
  output logic [7:0]  out_read_data,
  output logic        out_dma_start,
  output logic [15:0] out_dma_source,
  output logic        out_double_speed
);

  localparam int VRAM_DEPTH = 2 * VRAM_BANK_BYTES;
  localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
  localparam int VOFF_W     = $clog2(VRAM_BANK_BYTES);
  localparam int OAM_AW     = $clog2(OAM_BYTES);
  localparam int PAL_AW     = $clog2(PALETTE_BYTES);
  localparam logic [16:0] VRAM_END = 17'(int'(VRAM_BASE) + VRAM_BANK_BYTES);
  localparam logic [16:0] OAM_END  = 17'(int'(OAM_BASE) + OAM_BYTES);

  typedef enum logic [2:0] {
    RSEL_REG   = 3'd0,
    RSEL_VRAM  = 3'd1,
    RSEL_OAM   = 3'd2,
    RSEL_BGPAL = 3'd3,
    RSEL_OBPAL = 3'd4
  } rsel_t;

  // Display and control registers
  logic [7:0] lcdc_r, lcdc_nxt;
  logic [3:0] stat_en_r, stat_en_nxt;
  logic [7:0] scy_r, scy_nxt, scx_r, scx_nxt, wy_r, wy_nxt, wx_r, wx_nxt;
  logic [7:0] lyc_r, lyc_nxt, dma_r, dma_nxt;
  logic [7:0] bgp_r, bgp_nxt, obp0_r, obp0_nxt, obp1_r, obp1_nxt;
  logic       armed_r, armed_nxt, double_r, double_nxt;
  logic [7:0] vbk_r, vbk_nxt;
  logic [7:0] bg_idx_r, bg_idx_nxt, ob_idx_r, ob_idx_nxt;
  logic [VRAM_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // Memories and their registered read data
  logic [7:0] vram_mem  [VRAM_DEPTH];
  logic [7:0] oam_mem   [OAM_BYTES];
  logic [7:0] bgpal_mem [PALETTE_BYTES];
  logic [7:0] obpal_mem [PALETTE_BYTES];
  logic [7:0] vram_rd_r, oam_rd_r, bgpal_rd_r, obpal_rd_r;

  // Item stage between accept and result load
  rsel_t      rsel_r, rsel_nxt;
  logic [7:0] reg_byte_r, reg_byte_nxt;
  logic       dma_hit_r, dma_hit_nxt;
  logic [7:0] dma_byte_r, dma_byte_nxt;

  // Result register
  logic [7:0]  out_rd_r;
  logic        out_dma_r;
  logic [15:0] out_src_r;
  logic        out_dbl_r;

  logic              clr;
  logic              is_read, is_write, acc_rd, acc_wr;
  logic              draw_block, oam_block;
  logic              vram_hit, oam_hit;
  logic [VOFF_W-1:0] vram_off;
  logic [VRAM_AW-1:0] vram_addr;
  logic [OAM_AW-1:0] oam_off;
  logic [PAL_AW-1:0] bg_entry, ob_entry;
  logic              vram_we, oam_we, bgpal_we, obpal_we;
  logic [VRAM_AW-1:0] vram_wa;
  logic [OAM_AW-1:0] oam_wa;
  logic [PAL_AW-1:0] bgpal_wa, obpal_wa;
  logic [7:0]        mem_wd;
  logic [7:0]        res_byte;

  // Decode
  assign clr        = cmd_i.clear_en;
  assign is_read    = (in_cmd == CMD_READ);
  assign is_write   = (in_cmd == CMD_WRITE);
  assign acc_rd     = cmd_i.accept && is_read;
  assign acc_wr     = cmd_i.accept && is_write;
  assign draw_block = lcdc_r[7] && (in_ppu_mode == MODE_DRAW);
  assign oam_block  = lcdc_r[7] && ((in_ppu_mode == MODE_SCAN) || (in_ppu_mode == MODE_DRAW));
  assign vram_hit   = (in_address >= VRAM_BASE) && ({1'b0, in_address} < VRAM_END);
  assign oam_hit    = (in_address >= OAM_BASE) && ({1'b0, in_address} < OAM_END);
  assign vram_off   = VOFF_W'(in_address - VRAM_BASE);
  assign vram_addr  = {vbk_r[0], vram_off};
  assign oam_off    = OAM_AW'(in_address - OAM_BASE);
  assign bg_entry   = bg_idx_r[PAL_AW-1:0];
  assign ob_entry   = ob_idx_r[PAL_AW-1:0];

  // Memory write ports: clearing sweep after reset, else CPU writes
  assign mem_wd   = clr ? 8'h00 : in_write_data;
  assign vram_we  = clr || (acc_wr && vram_hit && !draw_block);
  assign vram_wa  = clr ? clr_cnt_r : vram_addr;
  assign oam_we   = clr ? (clr_cnt_r < VRAM_AW'(OAM_BYTES))
                        : (acc_wr && oam_hit && !oam_block);
  assign oam_wa   = clr ? OAM_AW'(clr_cnt_r) : oam_off;
  assign bgpal_we = clr ? (clr_cnt_r < VRAM_AW'(PALETTE_BYTES))
                        : (acc_wr && (in_address == ADDR_BCPD) && !draw_block);
  assign bgpal_wa = clr ? PAL_AW'(clr_cnt_r) : bg_entry;
  assign obpal_we = clr ? (clr_cnt_r < VRAM_AW'(PALETTE_BYTES))
                        : (acc_wr && (in_address == ADDR_OCPD) && !draw_block);
  assign obpal_wa = clr ? PAL_AW'(clr_cnt_r) : ob_entry;

  always_ff @(posedge clk) begin
    if (vram_we) begin
      vram_mem[vram_wa] <= mem_wd;
    end
    if (acc_rd && vram_hit) begin
      vram_rd_r <= vram_mem[vram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (oam_we) begin
      oam_mem[oam_wa] <= mem_wd;
    end
    if (acc_rd && oam_hit) begin
      oam_rd_r <= oam_mem[oam_off];
    end
  end

  always_ff @(posedge clk) begin
    if (bgpal_we) begin
      bgpal_mem[bgpal_wa] <= mem_wd;
    end
    if (acc_rd && (in_address == ADDR_BCPD)) begin
      bgpal_rd_r <= bgpal_mem[bg_entry];
    end
  end

  always_ff @(posedge clk) begin
    if (obpal_we) begin
      obpal_mem[obpal_wa] <= mem_wd;
    end
    if (acc_rd && (in_address == ADDR_OCPD)) begin
      obpal_rd_r <= obpal_mem[ob_entry];
    end
  end

  assign clr_cnt_nxt       = clr ? clr_cnt_r + 1'b1 : clr_cnt_r;
  assign stat_o.clear_last = (clr_cnt_r == {VRAM_AW{1'b1}});

  // Read byte and memory select for an accepted read
  always_comb begin
    rsel_nxt     = RSEL_REG;
    reg_byte_nxt = 8'h00;
    if (is_read) begin
      if (vram_hit) begin
        reg_byte_nxt = OPEN_BUS;
        rsel_nxt     = draw_block ? RSEL_REG : RSEL_VRAM;
      end else if (oam_hit) begin
        reg_byte_nxt = OPEN_BUS;
        rsel_nxt     = oam_block ? RSEL_REG : RSEL_OAM;
      end else begin
        unique case (in_address)
          ADDR_LCDC: reg_byte_nxt = lcdc_r;
          ADDR_STAT: reg_byte_nxt = STAT_TOP | {1'b0, stat_en_r, in_stat_status};
          ADDR_SCY:  reg_byte_nxt = scy_r;
          ADDR_SCX:  reg_byte_nxt = scx_r;
          ADDR_LY:   reg_byte_nxt = in_current_line;
          ADDR_LYC:  reg_byte_nxt = lyc_r;
          ADDR_DMA:  reg_byte_nxt = dma_r;
          ADDR_BGP:  reg_byte_nxt = bgp_r;
          ADDR_OBP0: reg_byte_nxt = obp0_r;
          ADDR_OBP1: reg_byte_nxt = obp1_r;
          ADDR_WY:   reg_byte_nxt = wy_r;
          ADDR_WX:   reg_byte_nxt = wx_r;
          ADDR_KEY1: reg_byte_nxt = KEY1_ONES | {double_r, 6'b000000, armed_r};
          ADDR_VBK:  reg_byte_nxt = vbk_r | VBK_ONES;
          ADDR_BCPS: reg_byte_nxt = draw_block ? OPEN_BUS : (bg_idx_r | PIDX_ONES);
          ADDR_OCPS: reg_byte_nxt = draw_block ? OPEN_BUS : (ob_idx_r | PIDX_ONES);
          ADDR_BCPD: begin
            reg_byte_nxt = OPEN_BUS;
            rsel_nxt     = draw_block ? RSEL_REG : RSEL_BGPAL;
          end
          ADDR_OCPD: begin
            reg_byte_nxt = OPEN_BUS;
            rsel_nxt     = draw_block ? RSEL_REG : RSEL_OBPAL;
          end
          default: reg_byte_nxt = OPEN_BUS;
        endcase
      end
    end
  end

  assign dma_hit_nxt  = is_write && (in_address == ADDR_DMA);
  assign dma_byte_nxt = dma_hit_nxt ? in_write_data : 8'h00;

  // Register writes and speed switch
  always_comb begin
    lcdc_nxt    = lcdc_r;
    stat_en_nxt = stat_en_r;
    scy_nxt     = scy_r;
    scx_nxt     = scx_r;
    wy_nxt      = wy_r;
    wx_nxt      = wx_r;
    lyc_nxt     = lyc_r;
    dma_nxt     = dma_r;
    bgp_nxt     = bgp_r;
    obp0_nxt    = obp0_r;
    obp1_nxt    = obp1_r;
    armed_nxt   = armed_r;
    double_nxt  = double_r;
    vbk_nxt     = vbk_r;
    bg_idx_nxt  = bg_idx_r;
    ob_idx_nxt  = ob_idx_r;
    if (acc_wr) begin
      unique case (in_address)
        ADDR_LCDC: lcdc_nxt    = in_write_data;
        ADDR_STAT: stat_en_nxt = in_write_data[6:3];
        ADDR_SCY:  scy_nxt     = in_write_data;
        ADDR_SCX:  scx_nxt     = in_write_data;
        ADDR_WY:   wy_nxt      = in_write_data;
        ADDR_WX:   wx_nxt      = in_write_data;
        ADDR_LYC:  lyc_nxt     = in_write_data;
        ADDR_DMA:  dma_nxt     = in_write_data;
        ADDR_BGP:  bgp_nxt     = in_write_data;
        ADDR_OBP0: obp0_nxt    = in_write_data;
        ADDR_OBP1: obp1_nxt    = in_write_data;
        ADDR_KEY1: armed_nxt   = in_write_data[0];
        ADDR_VBK:  vbk_nxt     = in_write_data;
        ADDR_BCPS: if (!draw_block) bg_idx_nxt = in_write_data;
        ADDR_OCPS: if (!draw_block) ob_idx_nxt = in_write_data;
        // data port write bumps the index when auto-increment is set
        ADDR_BCPD: if (!draw_block && bg_idx_r[7]) begin
          bg_idx_nxt = {1'b1, {(7 - PAL_AW){1'b0}}, bg_entry + 1'b1};
        end
        ADDR_OCPD: if (!draw_block && ob_idx_r[7]) begin
          ob_idx_nxt = {1'b1, {(7 - PAL_AW){1'b0}}, ob_entry + 1'b1};
        end
        default: ;
      endcase
    end else if (cmd_i.accept && (in_cmd == CMD_SPEED) && armed_r) begin
      double_nxt = !double_r;
      armed_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcdc_r    <= '0;
      stat_en_r <= '0;
      scy_r     <= '0;
      scx_r     <= '0;
      wy_r      <= '0;
      wx_r      <= '0;
      lyc_r     <= '0;
      dma_r     <= '0;
      bgp_r     <= '0;
      obp0_r    <= '0;
      obp1_r    <= '0;
      armed_r   <= 1'b0;
      double_r  <= 1'b0;
      vbk_r     <= '0;
      bg_idx_r  <= '0;
      ob_idx_r  <= '0;
      clr_cnt_r <= '0;
    end else begin
      lcdc_r    <= lcdc_nxt;
      stat_en_r <= stat_en_nxt;
      scy_r     <= scy_nxt;
      scx_r     <= scx_nxt;
      wy_r      <= wy_nxt;
      wx_r      <= wx_nxt;
      lyc_r     <= lyc_nxt;
      dma_r     <= dma_nxt;
      bgp_r     <= bgp_nxt;
      obp0_r    <= obp0_nxt;
      obp1_r    <= obp1_nxt;
      armed_r   <= armed_nxt;
      double_r  <= double_nxt;
      vbk_r     <= vbk_nxt;
      bg_idx_r  <= bg_idx_nxt;
      ob_idx_r  <= ob_idx_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Item stage, captured at accept
  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      rsel_r     <= rsel_nxt;
      reg_byte_r <= reg_byte_nxt;
      dma_hit_r  <= dma_hit_nxt;
      dma_byte_r <= dma_byte_nxt;
    end
  end

  // Final read byte
  always_comb begin
    unique case (rsel_r)
      RSEL_VRAM:  res_byte = vram_rd_r;
      RSEL_OAM:   res_byte = oam_rd_r;
      RSEL_BGPAL: res_byte = bgpal_rd_r;
      RSEL_OBPAL: res_byte = obpal_rd_r;
      default:    res_byte = reg_byte_r;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_rd_r  <= res_byte;
      out_dma_r <= dma_hit_r;
      out_src_r <= {dma_byte_r, 8'h00};
      out_dbl_r <= double_r;
    end
  end

  assign out_read_data    = out_rd_r;
  assign out_dma_start    = out_dma_r;
  assign out_dma_source   = out_src_r;
  assign out_double_speed = out_dbl_r;

endmodule

// ----- rtl/video_unit_cpu_access_port.sv -----
// Top level: CPU access port of the display unit (registers, VRAM, OAM, palettes).
`timescale 1ns / 1ps
// Usage:
//   in_ch  : one CPU access per transfer (cmd read/write/speed switch, address,
//            write byte) together with the live display mode, line and status.
//   out_ch : exactly one result per access: read byte (0xFF when blocked or
//            unmapped, 0 for writes), object DMA start flag and source, and the
//            double speed bit after the access.
//   Flow: the transfer moves the controller to its result state, which loads
//   the result into the output register once that register is free; out_ch
//   takes it from there. One access is in flight: no new access is taken
//   until the result is loaded, as the memory read port is registered.
//   Reset: after rst_n is released the block sweeps video RAM, sprite RAM and
//   both palette RAMs to zero over 2*VRAM_BANK_BYTES addresses (16384), with
//   in_ch ready held low. Registers clear at once.
//   Stall: a finished result waits in the output register; the next access is
//   still taken and its result is held back until out_ch takes the older one.
module video_unit_cpu_access_port
  import vuap_pkg::*;
#(
  parameter int VRAM_BANK_BYTES = VRAM_BANK_BYTES_C,
  parameter int OAM_BYTES       = OAM_BYTES_C,
  parameter int PALETTE_BYTES   = PALETTE_BYTES_C
) (
  input  logic       clk,
  input  logic       rst_n,
  vuap_in_if.sink    in_ch,
  vuap_out_if.source out_ch
);

  vuap_cmd_t  cmd;
  vuap_stat_t stat;

  vuap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  vuap_dp #(
    .VRAM_BANK_BYTES (VRAM_BANK_BYTES),
    .OAM_BYTES       (OAM_BYTES),
    .PALETTE_BYTES   (PALETTE_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .in_cmd           (in_ch.cmd),
    .in_address       (in_ch.address),
    .in_write_data    (in_ch.write_data),
    .in_ppu_mode      (in_ch.ppu_mode),
    .in_current_line  (in_ch.current_line),
    .in_stat_status   (in_ch.stat_status),
    .out_read_data    (out_ch.read_data),
    .out_dma_start    (out_ch.dma_start),
    .out_dma_source   (out_ch.dma_source),
    .out_double_speed (out_ch.double_speed)
  );

endmodule

// ----- rtl/vuap_chk.sv -----
// Port checker for the access port, bound to the top level.
`timescale 1ns / 1ps
module vuap_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_dma_start,
  input logic [15:0] out_dma_source
);

  // one access in flight: ready drops right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an access is in flight");

  // with a free output register, the result state loads the result and out_valid follows
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (!out_valid || out_ready)) |-> ##2 out_valid)
    else $error("result missing two cycles after transfer");

  // DMA source is a page address, and zero without a DMA start
  a_dma_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_dma_source[7:0] == 8'h00) &&
                   (out_dma_start || (out_dma_source == 16'h0000))))
    else $error("bad DMA source on result");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind video_unit_cpu_access_port vuap_chk u_vuap_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_dma_start  (out_ch.dma_start),
  .out_dma_source (out_ch.dma_source)
);

// ----- bench/vuap_access_check.sv -----
// Access checker: predicts each CPU access result and compares it with the port output.
`timescale 1ns / 1ps
module vuap_access_check
  import vuap_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  vuap_in_if   in_ch,
  vuap_out_if  out_ch,
  output int   fail_count,
  output int   pending_count,
  output int   checked_count,
  output int   blocked_count,
  output int   dma_count,
  output int   toggle_count
);

  localparam int REPORT_LINES = 50;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  wdata;
    logic [1:0]  mode;
    logic [7:0]  line;
    logic [2:0]  status;
  } cpu_access_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        dma_start;
    logic [15:0] dma_source;
    logic        double_speed;
  } access_result_t;

  // Shadow copy of the port's memories and registers
  logic [7:0] vram_shadow [0:2*VRAM_BANK_BYTES_C-1];
  logic [7:0] oam_shadow  [0:OAM_BYTES_C-1];
  logic [7:0] bg_pal      [0:PALETTE_BYTES_C-1];
  logic [7:0] obj_pal     [0:PALETTE_BYTES_C-1];
  logic [7:0] lcdc_q, scy_q, scx_q, wy_q, wx_q, lyc_q, dma_q;
  logic [7:0] bgp_q, obp0_q, obp1_q, vbk_q, bg_idx_q, obj_idx_q;
  logic [3:0] stat_en_q;
  logic       speed_armed_q, speed_double_q;

  access_result_t due_results [$];

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count++;
    if (fail_count <= REPORT_LINES)
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Register file reads (everything outside VRAM and OAM)
  function automatic logic [7:0] read_register(cpu_access_t acc, logic draw_blk);
    case (acc.address)
      ADDR_LCDC: return lcdc_q;
      ADDR_STAT: return STAT_TOP | {1'b0, stat_en_q, acc.status};
      ADDR_SCY:  return scy_q;
      ADDR_SCX:  return scx_q;
      ADDR_LY:   return acc.line;
      ADDR_LYC:  return lyc_q;
      ADDR_DMA:  return dma_q;
      ADDR_BGP:  return bgp_q;
      ADDR_OBP0: return obp0_q;
      ADDR_OBP1: return obp1_q;
      ADDR_WY:   return wy_q;
      ADDR_WX:   return wx_q;
      ADDR_KEY1: return KEY1_ONES | {speed_double_q, 6'd0, speed_armed_q};
      ADDR_VBK:  return vbk_q | VBK_ONES;
      ADDR_BCPS: return draw_blk ? OPEN_BUS : (bg_idx_q | PIDX_ONES);
      ADDR_BCPD: return draw_blk ? OPEN_BUS : bg_pal[bg_idx_q[5:0]];
      ADDR_OCPS: return draw_blk ? OPEN_BUS : (obj_idx_q | PIDX_ONES);
      ADDR_OCPD: return draw_blk ? OPEN_BUS : obj_pal[obj_idx_q[5:0]];
      default:   return OPEN_BUS;
    endcase
  endfunction

  // Apply one access to the shadow state and return its result
  function automatic access_result_t apply_access(cpu_access_t acc);
    access_result_t res;
    logic draw_blk, oam_blk, in_vram, in_oam, pal_port;
    logic [13:0] vidx;
    res      = '0;
    draw_blk = lcdc_q[7] && acc.mode == MODE_DRAW;
    oam_blk  = lcdc_q[7] && (acc.mode == MODE_SCAN || acc.mode == MODE_DRAW);
    in_vram  = acc.address >= VRAM_BASE && acc.address < VRAM_BASE + VRAM_BANK_BYTES_C;
    in_oam   = acc.address >= OAM_BASE && acc.address < OAM_BASE + OAM_BYTES_C;
    pal_port = acc.address == ADDR_BCPS || acc.address == ADDR_BCPD ||
               acc.address == ADDR_OCPS || acc.address == ADDR_OCPD;
    vidx     = {vbk_q[0], acc.address[12:0]};

    if ((acc.cmd == CMD_READ || acc.cmd == CMD_WRITE) &&
        ((in_vram && draw_blk) || (in_oam && oam_blk) || (pal_port && draw_blk)))
      blocked_count++;

    if (acc.cmd == CMD_READ) begin
      if (in_vram)
        res.read_data = draw_blk ? OPEN_BUS : vram_shadow[vidx];
      else if (in_oam)
        res.read_data = oam_blk ? OPEN_BUS : oam_shadow[acc.address[7:0]];
      else
        res.read_data = read_register(acc, draw_blk);
    end else if (acc.cmd == CMD_WRITE) begin
      if (in_vram) begin
        if (!draw_blk) vram_shadow[vidx] = acc.wdata;
      end else if (in_oam) begin
        if (!oam_blk) oam_shadow[acc.address[7:0]] = acc.wdata;
      end else begin
        case (acc.address)
          ADDR_LCDC: lcdc_q = acc.wdata;
          ADDR_STAT: stat_en_q = acc.wdata[6:3];
          ADDR_SCY:  scy_q = acc.wdata;
          ADDR_SCX:  scx_q = acc.wdata;
          ADDR_LYC:  lyc_q = acc.wdata;
          ADDR_DMA: begin
            dma_q          = acc.wdata;
            res.dma_start  = 1'b1;
            res.dma_source = {acc.wdata, 8'h00};
            dma_count++;
          end
          ADDR_BGP:  bgp_q = acc.wdata;
          ADDR_OBP0: obp0_q = acc.wdata;
          ADDR_OBP1: obp1_q = acc.wdata;
          ADDR_WY:   wy_q = acc.wdata;
          ADDR_WX:   wx_q = acc.wdata;
          ADDR_KEY1: speed_armed_q = acc.wdata[0];
          ADDR_VBK:  vbk_q = acc.wdata;
          ADDR_BCPS: if (!draw_blk) bg_idx_q = acc.wdata;
          ADDR_OCPS: if (!draw_blk) obj_idx_q = acc.wdata;
          // data ports: store, then step the index when auto-increment is on
          ADDR_BCPD: if (!draw_blk) begin
            bg_pal[bg_idx_q[5:0]] = acc.wdata;
            if (bg_idx_q[7]) bg_idx_q = {2'b10, bg_idx_q[5:0] + 6'd1};
          end
          ADDR_OCPD: if (!draw_blk) begin
            obj_pal[obj_idx_q[5:0]] = acc.wdata;
            if (obj_idx_q[7]) obj_idx_q = {2'b10, obj_idx_q[5:0] + 6'd1};
          end
          default: ;
        endcase
      end
    end else if (acc.cmd == CMD_SPEED) begin
      if (speed_armed_q) begin
        speed_double_q = ~speed_double_q;
        speed_armed_q  = 1'b0;
        toggle_count++;
      end
    end

    res.double_speed = speed_double_q;
    return res;
  endfunction

  // Watch both channels at the rising edge
  always @(posedge clk) begin : watch
    cpu_access_t    acc;
    access_result_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < 2*VRAM_BANK_BYTES_C; i++) vram_shadow[i] = '0;
      for (int i = 0; i < OAM_BYTES_C; i++) oam_shadow[i] = '0;
      for (int i = 0; i < PALETTE_BYTES_C; i++) begin
        bg_pal[i]  = '0;
        obj_pal[i] = '0;
      end
      {lcdc_q, scy_q, scx_q, wy_q, wx_q, lyc_q, dma_q} = '0;
      {bgp_q, obp0_q, obp1_q, vbk_q, bg_idx_q, obj_idx_q} = '0;
      stat_en_q      = '0;
      speed_armed_q  = 1'b0;
      speed_double_q = 1'b0;
      due_results.delete();
      fail_count    = 0;
      checked_count = 0;
      blocked_count = 0;
      dma_count     = 0;
      toggle_count  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.read_data, out_ch.dma_start, out_ch.dma_source, out_ch.double_speed};
        if (due_results.size() == 0) begin
          report_mismatch("result with no access outstanding", 16'(got.read_data), '0);
        end else begin
          want = due_results.pop_front();
          checked_count++;
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", 16'(got.read_data), 16'(want.read_data));
          if (got.dma_start !== want.dma_start)
            report_mismatch("dma_start", 16'(got.dma_start), 16'(want.dma_start));
          if (got.dma_source !== want.dma_source)
            report_mismatch("dma_source", got.dma_source, want.dma_source);
          if (got.double_speed !== want.double_speed)
            report_mismatch("double_speed", 16'(got.double_speed),
                            16'(want.double_speed));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        acc = {in_ch.cmd, in_ch.address, in_ch.write_data, in_ch.ppu_mode,
               in_ch.current_line, in_ch.stat_status};
        due_results.push_back(apply_access(acc));
      end
    end
    pending_count = due_results.size();
  end

endmodule

// ----- bench/tb_video_unit_cpu_access_port.sv -----
// Testbench top: clock, reset, CPU access stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module tb_video_unit_cpu_access_port
  import vuap_pkg::*;
;

  localparam logic [1:0]  CMD_NONE     = 2'd3;       // unused command code
  localparam logic [15:0] HDMA_SRC_HI  = 16'hFF51;   // unmapped here
  localparam int          NUM_REGS     = 19;
  localparam int          RANDOM_ITEMS = 850;
  localparam int          TAIL_ITEMS   = 150;
  localparam int          SETTLE       = 10;
  // reset sweep plus every item at worst gap, stall and cadence, times several
  localparam int          CYCLE_LIMIT  = 300000;

  logic clk;
  logic rst_n;
  int   gap_pct   = 0;
  int   stall_pct = 0;
  int   cycle_count;
  int   random_items, n_reads, n_writes, n_speed, n_none;
  int   fail_count, pending_count, checked_count, blocked_count, dma_count, toggle_count;

  vuap_in_if  in_ch ();
  vuap_out_if out_ch ();

  video_unit_cpu_access_port dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  vuap_access_check access_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .checked_count(checked_count),
    .blocked_count(blocked_count),
    .dma_count    (dma_count),
    .toggle_count (toggle_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Mapped registers plus one unmapped HDMA address
  function automatic logic [15:0] reg_addr(int k);
    case (k)
      0:  return ADDR_LCDC;
      1:  return ADDR_STAT;
      2:  return ADDR_SCY;
      3:  return ADDR_SCX;
      4:  return ADDR_LY;
      5:  return ADDR_LYC;
      6:  return ADDR_DMA;
      7:  return ADDR_BGP;
      8:  return ADDR_OBP0;
      9:  return ADDR_OBP1;
      10: return ADDR_WY;
      11: return ADDR_WX;
      12: return ADDR_KEY1;
      13: return ADDR_VBK;
      14: return ADDR_BCPS;
      15: return ADDR_BCPD;
      16: return ADDR_OCPS;
      17: return ADDR_OCPD;
      default: return HDMA_SRC_HI;
    endcase
  endfunction

  // One transfer on the input channel; entered and left at a falling edge
  task automatic send(input logic [1:0] cmd, input logic [15:0] addr, input logic [7:0] data,
                      input logic [1:0] mode, input logic [7:0] line, input logic [2:0] status);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= cmd;
    in_ch.address      <= addr;
    in_ch.write_data   <= data;
    in_ch.ppu_mode     <= mode;
    in_ch.current_line <= line;
    in_ch.stat_status  <= status;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    case (cmd)
      CMD_READ:  n_reads++;
      CMD_WRITE: n_writes++;
      CMD_SPEED: n_speed++;
      default:   n_none++;
    endcase
  endtask

  // Access with random live renderer inputs
  task automatic send_rand(input logic [1:0] cmd, input logic [15:0] addr,
                           input logic [7:0] data);
    send(cmd, addr, data, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 153)),
         3'($urandom_range(0, 7)));
    if (cmd != CMD_NONE) random_items++;
  endtask

  // Hold off the sender until every outstanding result has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Output back-pressure in random bursts
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
    $display("** video_unit_cpu_access_port: FAILED **");
    $finish;
  end

  // Stimulus
  initial begin
    int          pick, phase_mark;
    logic        drained_mid;
    logic [15:0] a;
    logic [7:0]  v;
    logic [12:0] off;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = '0;
    in_ch.address      = '0;
    in_ch.write_data   = '0;
    in_ch.ppu_mode     = '0;
    in_ch.current_line = '0;
    in_ch.stat_status  = '0;
    random_items = 0;
    n_reads      = 0;
    n_writes     = 0;
    n_speed      = 0;
    n_none       = 0;
    phase_mark   = 0;
    drained_mid  = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset values, masks, speed switch, palette wrap, banks, blocking
    gap_pct   = 30;
    stall_pct = 30;
    send(CMD_READ,  ADDR_LCDC, 8'h00, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_READ,  ADDR_KEY1, 8'h00, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_READ,  ADDR_VBK,  8'h00, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_WRITE, ADDR_STAT, 8'hFF, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_READ,  ADDR_STAT, 8'h00, MODE_DRAW,   8'd153, 3'd7);
    send(CMD_WRITE, ADDR_LY,   8'h55, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_READ,  ADDR_LY,   8'h00, MODE_VBLANK, 8'd153, 3'd0);
    send(CMD_SPEED, 16'h0000,  8'h00, MODE_HBLANK, 8'd0, 3'd0);   // not armed
    send(CMD_WRITE, ADDR_KEY1, 8'hFF, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_SPEED, 16'hFFFF,  8'hFF, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_READ,  ADDR_KEY1, 8'h00, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_WRITE, ADDR_BCPS, 8'hBF, MODE_HBLANK, 8'd0, 3'd0);   // last entry, auto-inc
    send(CMD_WRITE, ADDR_BCPD, 8'hAA, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_READ,  ADDR_BCPS, 8'h00, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_WRITE, ADDR_VBK,  8'hFF, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_WRITE, VRAM_BASE + 16'h1FFF, 8'h5A, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_READ,  VRAM_BASE + 16'h1FFF, 8'h00, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_WRITE, OAM_BASE + 16'd159, 8'hC3, MODE_SCAN, 8'd0, 3'd0);
    send(CMD_READ,  OAM_BASE + 16'd160, 8'h00, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_WRITE, ADDR_DMA,  8'hFF, MODE_HBLANK, 8'd0, 3'd0);
    send(CMD_WRITE, ADDR_LCDC, 8'h80, MODE_HBLANK, 8'd0, 3'd0);   // display on
    send(CMD_READ,  VRAM_BASE + 16'h1FFF, 8'h00, MODE_DRAW, 8'd0, 3'd0);
    send(CMD_READ,  OAM_BASE + 16'd159, 8'h00, MODE_SCAN, 8'd0, 3'd0);
    send(CMD_WRITE, ADDR_OCPD, 8'h77, MODE_DRAW, 8'd0, 3'd0);
    send(CMD_NONE,  ADDR_LCDC, 8'h00, MODE_HBLANK, 8'd0, 3'd0);

    // Random: mostly short well-formed sequences, some raw noise
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= phase_mark) begin
        phase_mark += 100;
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      if (random_items >= RANDOM_ITEMS - TAIL_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      if (!drained_mid && random_items >= RANDOM_ITEMS / 2) begin
        drain();
        drained_mid = 1'b1;
      end

      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // single register access
        send_rand($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                  reg_addr($urandom_range(0, NUM_REGS - 1)), 8'($urandom_range(0, 255)));
      end else if (pick < 30) begin
        // palette: set index (mostly auto-inc), run the data port, read back
        a = $urandom_range(0, 1) ? ADDR_BCPS : ADDR_OCPS;
        v = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) v[7] = 1'b1;
        send_rand(CMD_WRITE, a, v);
        repeat ($urandom_range(2, 6))
          send_rand($urandom_range(0, 3) == 0 ? CMD_READ : CMD_WRITE, a + 16'd1,
                    8'($urandom_range(0, 255)));
        send_rand(CMD_READ, a, 8'h00);
        send_rand(CMD_READ, a + 16'd1, 8'h00);
      end else if (pick < 45) begin
        // video RAM: optional bank switch, then accesses clustered at both ends
        if ($urandom_range(0, 1)) send_rand(CMD_WRITE, ADDR_VBK, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(2, 6)) begin
          case ($urandom_range(0, 3))
            0:       off = 13'($urandom_range(0, 15));
            1:       off = 13'h1FF0 + 13'($urandom_range(0, 15));
            default: off = 13'($urandom_range(0, 8191));
          endcase
          send_rand($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, VRAM_BASE + off,
                    8'($urandom_range(0, 255)));
        end
      end else if (pick < 58) begin
        // sprite RAM, including the unmapped tail above it
        repeat ($urandom_range(2, 6)) begin
          off = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(160, 255)) :
                ($urandom_range(0, 1) ? 13'($urandom_range(0, 7)) :
                                        13'($urandom_range(150, 159)));
          send_rand($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, OAM_BASE + off,
                    8'($urandom_range(0, 255)));
        end
      end else if (pick < 66) begin
        // speed switch: arm (usually), stop event, read back
        v = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) v[0] = 1'b1;
        send_rand(CMD_WRITE, ADDR_KEY1, v);
        send_rand(CMD_SPEED, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        send_rand(CMD_READ, ADDR_KEY1, 8'h00);
      end else if (pick < 73) begin
        send_rand(CMD_WRITE, ADDR_DMA, 8'($urandom_range(0, 255)));
        send_rand(CMD_READ, ADDR_DMA, 8'h00);
      end else if (pick < 81) begin
        // display enable flips the blocking rules
        send_rand(CMD_WRITE, ADDR_LCDC, 8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        send_rand(2'($urandom_range(0, 3)), reg_addr($urandom_range(0, NUM_REGS - 1)),
                  8'($urandom_range(0, 255)));
      end else begin
        send_rand(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)));
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk);

    $display("Covered %0d accesses: %0d reads, %0d writes, %0d speed events, %0d no-ops.",
             n_reads + n_writes + n_speed + n_none, n_reads, n_writes, n_speed, n_none);
    $display("Checked %0d results; %0d mode-blocked accesses, %0d DMA starts, %0d speed toggles.",
             checked_count, blocked_count, dma_count, toggle_count);
    if (fail_count == 0) begin
      $display("** video_unit_cpu_access_port: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** video_unit_cpu_access_port: FAILED **");
    end
    $finish;
  end

endmodule

// ----- video_unit_cpu_access_port.f -----
rtl/vuap_pkg.sv
rtl/vuap_ifs.sv
rtl/vuap_ctrl.sv
rtl/vuap_dp.sv
rtl/video_unit_cpu_access_port.sv
rtl/vuap_chk.sv
bench/vuap_access_check.sv
bench/tb_video_unit_cpu_access_port.sv
